### rtl/crcfe_pkg.sv
package crcfe_pkg;

   localparam int unsigned MaxPayloadDefault = 1024;
   localparam int unsigned MaxResults = 6;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [7:0] MAGIC_RESET = 8'hAA;

   localparam logic OP_START = 1'b0;
   localparam logic OP_DATA = 1'b1;

   localparam logic [1:0] STAT_OK = 2'd0;
   localparam logic [1:0] STAT_TOO_LONG = 2'd1;
   localparam logic [1:0] STAT_STRAY = 2'd2;

   typedef struct packed {
      logic opcode;
      logic [7:0] frame_type;
      logic [15:0] payload_length;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic frame_end;
      logic [1:0] status;
   } rsp_type;

   // One byte of CRC-16-CCITT, MSB first.
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

### rtl/crc16_frame_encoder_core.sv
// Frame encoder: turns start and payload words into a framed byte stream.
// Input channel req_*: a start word (opcode 0) carries the frame type and the
// payload length; a payload word (opcode 1) carries one data byte. Result
// channel rsp_*: one encoded byte per word, with frame_end and status.
// A frame is magic, type, length low, length high, payload, CRC low, CRC high.
// The CRC is CRC-16-CCITT (init 0xFFFF) over type, length and payload.
// csr_*: write port for the magic byte; it is always ready.
// A request word is held in the input register and is then expanded into
// the result buffer, whose head drives rsp_*. Each word produces 1 to 6
// bytes, sent at one byte per cycle while rsp_stall is low; the next word is
// expanded in the cycle the last byte of the previous one leaves. Payload
// words that produce one byte therefore run at one word per cycle while
// rsp_stall is low; a payload word that closes a frame produces 3 bytes and a
// valid start word 4 or 6, all sent through the single output port.
// Status-only results are a single byte.
// Reset clears the open frame, sets the CRC to 0xFFFF and the magic to 0xAA.
// When the receiver stalls, the current byte and the rest of the buffer
// hold, and one further request word is held in the input register before
// req_stall rises.
module crc16_frame_encoder_core
   import crcfe_pkg::*;
#(
   parameter int unsigned MAX_PAYLOAD = MaxPayloadDefault
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  req_type req_word,
   output logic rsp_valid,
   input  logic rsp_stall,
   output rsp_type rsp_word,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [7:0] csr_data
);

   localparam int CntW = $clog2(MaxResults + 1);

   logic in_valid_ff;
   req_type in_word_ff;
   rsp_type buf_ff [MaxResults];
   logic [CntW-1:0] cnt_ff;
   logic [15:0] crc_ff;
   logic [15:0] remain_ff;
   logic open_ff;
   logic [7:0] magic_ff;

   rsp_type buf_in [MaxResults];
   logic [CntW-1:0] cnt_in;
   logic [15:0] crc_in;
   logic [15:0] remain_in;
   logic open_in;

   logic rsp_fire;
   logic load;
   logic [15:0] crc_a;
   logic [15:0] crc_b;
   logic [15:0] crc_hdr;
   logic [15:0] crc_pay;
   logic [15:0] remain_dec;
   logic too_long;

   assign rsp_valid = (cnt_ff != '0);
   assign rsp_word = buf_ff[0];
   assign rsp_fire = rsp_valid && !rsp_stall;
   assign load = in_valid_ff && ((cnt_ff == '0) || ((cnt_ff == CntW'(1)) && rsp_fire));
   assign req_stall = in_valid_ff && !load;
   assign csr_ready = 1'b1;

   assign crc_a = crc_feed(CRC_INIT, in_word_ff.frame_type);
   assign crc_b = crc_feed(crc_a, in_word_ff.payload_length[7:0]);
   assign crc_hdr = crc_feed(crc_b, in_word_ff.payload_length[15:8]);
   assign crc_pay = crc_feed(crc_ff, in_word_ff.data_byte);
   assign remain_dec = remain_ff - 16'd1;
   assign too_long = (in_word_ff.payload_length > 16'(MAX_PAYLOAD));

   // Expand the held request word into its full burst of result bytes.
   always_comb begin
      for (int i = 0; i < MaxResults; i++) begin
         buf_in[i] = '0;
      end
      cnt_in = '0;
      crc_in = crc_ff;
      remain_in = remain_ff;
      open_in = open_ff;
      if (in_word_ff.opcode == OP_START) begin
         if (too_long) begin
            buf_in[0] = '{out_byte: 8'h00, frame_end: 1'b1, status: STAT_TOO_LONG};
            cnt_in = CntW'(1);
            remain_in = '0;
            open_in = 1'b0;
         end else begin
            buf_in[0] = '{out_byte: magic_ff, frame_end: 1'b0, status: STAT_OK};
            buf_in[1] = '{out_byte: in_word_ff.frame_type, frame_end: 1'b0, status: STAT_OK};
            buf_in[2] = '{out_byte: in_word_ff.payload_length[7:0], frame_end: 1'b0,
                          status: STAT_OK};
            buf_in[3] = '{out_byte: in_word_ff.payload_length[15:8], frame_end: 1'b0,
                          status: STAT_OK};
            crc_in = crc_hdr;
            if (in_word_ff.payload_length == '0) begin
               buf_in[4] = '{out_byte: crc_hdr[7:0], frame_end: 1'b0, status: STAT_OK};
               buf_in[5] = '{out_byte: crc_hdr[15:8], frame_end: 1'b1, status: STAT_OK};
               cnt_in = CntW'(6);
               remain_in = '0;
               open_in = 1'b0;
            end else begin
               cnt_in = CntW'(4);
               remain_in = in_word_ff.payload_length;
               open_in = 1'b1;
            end
         end
      end else if (!open_ff) begin
         buf_in[0] = '{out_byte: 8'h00, frame_end: 1'b1, status: STAT_STRAY};
         cnt_in = CntW'(1);
      end else begin
         buf_in[0] = '{out_byte: in_word_ff.data_byte, frame_end: 1'b0, status: STAT_OK};
         crc_in = crc_pay;
         remain_in = remain_dec;
         if (remain_dec == '0) begin
            buf_in[1] = '{out_byte: crc_pay[7:0], frame_end: 1'b0, status: STAT_OK};
            buf_in[2] = '{out_byte: crc_pay[15:8], frame_end: 1'b1, status: STAT_OK};
            cnt_in = CntW'(3);
            open_in = 1'b0;
         end else begin
            cnt_in = CntW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         cnt_ff <= '0;
         crc_ff <= CRC_INIT;
         remain_ff <= '0;
         open_ff <= 1'b0;
         magic_ff <= MAGIC_RESET;
      end else begin
         if (req_valid && !req_stall) begin
            in_valid_ff <= 1'b1;
         end else if (load) begin
            in_valid_ff <= 1'b0;
         end
         if (load) begin
            cnt_ff <= cnt_in;
            crc_ff <= crc_in;
            remain_ff <= remain_in;
            open_ff <= open_in;
         end else if (rsp_fire) begin
            cnt_ff <= cnt_ff - CntW'(1);
         end
         if (csr_valid && csr_ready) begin
            magic_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_word_ff <= req_word;
      end
      if (load) begin
         buf_ff <= buf_in;
      end else if (rsp_fire) begin
         for (int i = 0; i < MaxResults - 1; i++) begin
            buf_ff[i] <= buf_ff[i+1];
         end
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntW'(MaxResults))
      else $error("result buffer count out of range");

   a_open_remain: assert property (@(posedge clock) disable iff (reset)
      open_ff == (remain_ff != '0))
      else $error("open frame and remaining byte count disagree");

   a_status_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status != STAT_OK) |-> rsp_word.frame_end && (cnt_ff == CntW'(1)))
      else $error("status result is not a lone final word");

   a_expand: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && (cnt_ff == '0) |=> cnt_ff != '0)
      else $error("held request word was not expanded");

endmodule
